// ===== sv/mmts_pkg.sv =====
package mmts_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_UNDER = 2'd1,
		STAT_OVER  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_REFILL
	} state_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic [DATA_WIDTH-1:0] lo;
		logic [DATA_WIDTH-1:0] hi;
	} entry_t;

	typedef struct packed {
		entry_t  ent;
		logic    empty;
		logic    full;
		status_t status;
	} result_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		entry_t            wdata;
	} ram_req_t;

endpackage

// ===== sv/min_max_tracking_stack_top.sv =====
// Signed stack of up to 256 words that reports, for every push or pop, the top word and the
// minimum and maximum of all held words, with empty, full and status flags. The top entry is
// cached in registers and every entry lives in a single-port synchronous memory with its running
// minimum and maximum. A push, a rejected operation or a pop that empties the stack produces its
// result in the idle state that accepts it; a pop that leaves entries produces it in the refill
// state, from the memory read that refills the cached top. Results pass through a two-word output
// buffer, so a word waiting on the output does not hold up the next input word.
module min_max_tracking_stack_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   op,
	input  logic signed [mmts_pkg::DATA_WIDTH-1:0] push_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mmts_pkg::DATA_WIDTH-1:0] top_value,
	output logic signed [mmts_pkg::DATA_WIDTH-1:0] min_value,
	output logic signed [mmts_pkg::DATA_WIDTH-1:0] max_value,
	output logic                                   is_empty,
	output logic                                   is_full,
	output logic [1:0]                             status
);

	mmts_pkg::ram_req_t ram_req;
	mmts_pkg::entry_t   ram_rdata;
	mmts_pkg::result_t  res;
	logic               res_valid;
	logic               room;

	mmts_pkg::result_t  buf_q [2];
	logic               wr_q, rd_q;
	logic [1:0]         cnt_q;
	logic               take;
	mmts_pkg::result_t  head;

	mmts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.push_value (push_value),
		.room       (room),
		.res_valid  (res_valid),
		.res        (res),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	mmts_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// at most one word in flight, so one free slot at accept is enough
	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && out_ready;
	assign head      = buf_q[rd_q];

	assign top_value = head.ent.value;
	assign min_value = head.ent.lo;
	assign max_value = head.ent.hi;
	assign is_empty  = head.empty;
	assign is_full   = head.full;
	assign status    = head.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_valid) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, res_valid} - {1'b0, take};
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			buf_q[wr_q] <= res;
		end
	end

endmodule

// ===== sv/mmts_ram.sv =====
module mmts_ram (
	input  logic               clk,
	input  mmts_pkg::ram_req_t req,
	output mmts_pkg::entry_t   rdata
);

	mmts_pkg::entry_t mem [mmts_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

// ===== sv/mmts_ctrl.sv =====
module mmts_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic signed [mmts_pkg::DATA_WIDTH-1:0] push_value,
	input  logic                                 room,
	output logic                                 res_valid,
	output mmts_pkg::result_t                    res,
	output mmts_pkg::ram_req_t                   ram_req,
	input  mmts_pkg::entry_t                     ram_rdata
);

	localparam logic [mmts_pkg::CNT_W-1:0] CNT_ONE  = mmts_pkg::CNT_W'(1);
	localparam logic [mmts_pkg::CNT_W-1:0] CNT_TWO  = mmts_pkg::CNT_W'(2);
	localparam logic [mmts_pkg::CNT_W-1:0] CNT_FULL = mmts_pkg::CNT_W'(mmts_pkg::DEPTH);

	mmts_pkg::state_t             state_q, state_d;
	logic [mmts_pkg::CNT_W-1:0]   count_q, count_d;
	mmts_pkg::entry_t             top_q, top_d;
	mmts_pkg::entry_t             push_ent;
	logic                         accept;

	function automatic mmts_pkg::result_t make_res(
		input mmts_pkg::entry_t           ent,
		input logic [mmts_pkg::CNT_W-1:0] cnt,
		input mmts_pkg::status_t          st
	);
		mmts_pkg::result_t r;
		r.ent    = (cnt == '0) ? '0 : ent;
		r.empty  = (cnt == '0);
		r.full   = (cnt == CNT_FULL);
		r.status = st;
		return r;
	endfunction

	assign in_ready = (state_q == mmts_pkg::ST_IDLE) && room;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push_ent.value = push_value;
		push_ent.lo    = push_value;
		push_ent.hi    = push_value;
		if (count_q != '0) begin
			if ($signed(top_q.lo) < push_value) begin
				push_ent.lo = top_q.lo;
			end
			if (push_value < $signed(top_q.hi)) begin
				push_ent.hi = top_q.hi;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mmts_pkg::ST_IDLE: begin
				if (accept && op == mmts_pkg::OP_POP && count_q >= CNT_TWO) begin
					state_d = mmts_pkg::ST_REFILL;
				end
			end
			mmts_pkg::ST_REFILL: begin
				state_d = mmts_pkg::ST_IDLE;
			end
			default: begin
				state_d = mmts_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_req   = '0;
		res_valid = 1'b0;
		res       = '0;
		count_d   = count_q;
		top_d     = top_q;
		case (state_q)
			mmts_pkg::ST_IDLE: begin
				if (accept) begin
					if (op == mmts_pkg::OP_PUSH) begin
						res_valid = 1'b1;
						if (count_q == CNT_FULL) begin
							res = make_res(top_q, count_q, mmts_pkg::STAT_OVER);
						end else begin
							ram_req.we    = 1'b1;
							ram_req.addr  = count_q[mmts_pkg::ADDR_W-1:0];
							ram_req.wdata = push_ent;
							top_d         = push_ent;
							count_d       = count_q + CNT_ONE;
							res = make_res(push_ent, count_d, mmts_pkg::STAT_OK);
						end
					end else begin
						if (count_q == '0) begin
							res_valid = 1'b1;
							res = make_res(top_q, count_q, mmts_pkg::STAT_UNDER);
						end else if (count_q == CNT_ONE) begin
							res_valid = 1'b1;
							count_d   = '0;
							res = make_res(top_q, count_d, mmts_pkg::STAT_OK);
						end else begin
							count_d      = count_q - CNT_ONE;
							ram_req.re   = 1'b1;
							ram_req.addr = mmts_pkg::ADDR_W'(count_q - CNT_TWO);
						end
					end
				end
			end
			mmts_pkg::ST_REFILL: begin
				top_d     = ram_rdata;
				res_valid = 1'b1;
				res       = make_res(ram_rdata, count_q, mmts_pkg::STAT_OK);
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmts_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
	end

endmodule

// ===== sv/mmts_checker.sv =====
module mmts_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [mmts_pkg::DATA_WIDTH-1:0] top_value,
	input logic signed [mmts_pkg::DATA_WIDTH-1:0] min_value,
	input logic signed [mmts_pkg::DATA_WIDTH-1:0] max_value,
	input logic                                   is_empty,
	input logic                                   is_full,
	input logic [1:0]                             status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(status))
		else $error("output word changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> top_value == '0 && min_value == '0 && max_value == '0)
		else $error("empty stack reports non-zero values");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mmts_pkg::STAT_UNDER |-> is_empty && !is_full)
		else $error("underflow on non-empty stack");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mmts_pkg::STAT_OVER |-> is_full && !is_empty)
		else $error("overflow on non-full stack");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_empty |-> min_value <= top_value && top_value <= max_value)
		else $error("top value outside running bounds");

endmodule

bind min_max_tracking_stack_top mmts_checker u_mmts_checker (.*);

// ===== test/min_max_stack_checker.sv =====
module min_max_stack_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic                                   op,
	input  logic signed [mmts_pkg::DATA_WIDTH-1:0] push_value,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [mmts_pkg::DATA_WIDTH-1:0] top_value,
	input  logic signed [mmts_pkg::DATA_WIDTH-1:0] min_value,
	input  logic signed [mmts_pkg::DATA_WIDTH-1:0] max_value,
	input  logic                                   is_empty,
	input  logic                                   is_full,
	input  logic [1:0]                             status,
	output int                                     errors,
	output int                                     pending,
	output int                                     results_seen,
	output int                                     underflows,
	output int                                     overflows
);

	localparam int REPORT_CAP = 50;

	logic signed [mmts_pkg::DATA_WIDTH-1:0] val_mem [mmts_pkg::DEPTH];
	logic signed [mmts_pkg::DATA_WIDTH-1:0] lo_mem  [mmts_pkg::DEPTH];
	logic signed [mmts_pkg::DATA_WIDTH-1:0] hi_mem  [mmts_pkg::DEPTH];
	int                                     held;
	mmts_pkg::result_t                      result_q [$];
	mmts_pkg::result_t                      oldest;

	function automatic mmts_pkg::result_t predict_stack(logic o,
			logic signed [mmts_pkg::DATA_WIDTH-1:0] v);
		mmts_pkg::result_t                      r;
		logic signed [mmts_pkg::DATA_WIDTH-1:0] lo;
		logic signed [mmts_pkg::DATA_WIDTH-1:0] hi;
		r = '0;
		r.status = mmts_pkg::STAT_OK;
		if (o == mmts_pkg::OP_PUSH) begin
			if (held >= mmts_pkg::DEPTH) begin
				r.status = mmts_pkg::STAT_OVER;
			end else begin
				lo = v;
				hi = v;
				if (held > 0) begin
					if (lo_mem[held-1] < v) lo = lo_mem[held-1];
					if (v < hi_mem[held-1]) hi = hi_mem[held-1];
				end
				val_mem[held] = v;
				lo_mem[held]  = lo;
				hi_mem[held]  = hi;
				held++;
			end
		end else if (held == 0) begin
			r.status = mmts_pkg::STAT_UNDER;
		end else begin
			held--;
		end
		if (held > 0) begin
			r.ent.value = val_mem[held-1];
			r.ent.lo    = lo_mem[held-1];
			r.ent.hi    = hi_mem[held-1];
		end
		r.empty = (held == 0);
		r.full  = (held == mmts_pkg::DEPTH);
		return r;
	endfunction

	task automatic check_field(string name, logic [mmts_pkg::DATA_WIDTH-1:0] want,
			logic [mmts_pkg::DATA_WIDTH-1:0] got);
		if (got !== want) begin
			if (errors < REPORT_CAP)
				$display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
					$time, name, $signed(want), want, $signed(got), got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			result_q.delete();
			errors = 0;
			results_seen = 0;
			underflows = 0;
			overflows = 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				result_q.insert(result_q.size(), predict_stack(op, push_value));
				if (result_q[$].status == mmts_pkg::STAT_UNDER) underflows++;
				if (result_q[$].status == mmts_pkg::STAT_OVER) overflows++;
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					if (errors < REPORT_CAP)
						$display("%0t: unexpected result word, expected none, actual top %0d status %0d",
							$time, top_value, status);
					errors++;
				end else begin
					oldest = result_q.pop_front();
					results_seen++;
					check_field("top_value", oldest.ent.value, top_value);
					check_field("min_value", oldest.ent.lo, min_value);
					check_field("max_value", oldest.ent.hi, max_value);
					check_field("is_empty", {{(mmts_pkg::DATA_WIDTH-1){1'b0}}, oldest.empty},
						{{(mmts_pkg::DATA_WIDTH-1){1'b0}}, is_empty});
					check_field("is_full", {{(mmts_pkg::DATA_WIDTH-1){1'b0}}, oldest.full},
						{{(mmts_pkg::DATA_WIDTH-1){1'b0}}, is_full});
					check_field("status", {{(mmts_pkg::DATA_WIDTH-2){1'b0}}, oldest.status},
						{{(mmts_pkg::DATA_WIDTH-2){1'b0}}, status});
				end
			end
			pending <= result_q.size();
		end
	end

endmodule

// ===== test/tb_min_max_tracking_stack_top.sv =====
module tb_min_max_tracking_stack_top;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 20;

	logic                                   clk;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_ready;
	logic                                   op = mmts_pkg::OP_PUSH;
	logic signed [mmts_pkg::DATA_WIDTH-1:0] push_value = '0;
	logic                                   out_valid;
	logic                                   out_ready = 1'b0;
	logic signed [mmts_pkg::DATA_WIDTH-1:0] top_value;
	logic signed [mmts_pkg::DATA_WIDTH-1:0] min_value;
	logic signed [mmts_pkg::DATA_WIDTH-1:0] max_value;
	logic                                   is_empty;
	logic                                   is_full;
	logic [1:0]                             status;

	int errors;
	int pending;
	int results_seen;
	int underflows;
	int overflows;
	bit idle_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int words_sent = 0;

	min_max_tracking_stack_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.push_value(push_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.top_value (top_value),
		.min_value (min_value),
		.max_value (max_value),
		.is_empty  (is_empty),
		.is_full   (is_full),
		.status    (status)
	);

	min_max_stack_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.top_value   (top_value),
		.min_value   (min_value),
		.max_value   (max_value),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.status      (status),
		.errors      (errors),
		.pending     (pending),
		.results_seen(results_seen),
		.underflows  (underflows),
		.overflows   (overflows)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!idle_on) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, pending);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic logic signed [mmts_pkg::DATA_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return {1'b1, {(mmts_pkg::DATA_WIDTH-1){1'b0}}};
			1:       return {1'b0, {(mmts_pkg::DATA_WIDTH-1){1'b1}}};
			2:       return '0;
			3:       return '1;
			4, 5:    return mmts_pkg::DATA_WIDTH'($signed($urandom_range(0, 16)) - 8);
			default: return mmts_pkg::DATA_WIDTH'($urandom);
		endcase
	endfunction

	task automatic send_word(logic o, logic signed [mmts_pkg::DATA_WIDTH-1:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		push_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic push_word(logic signed [mmts_pkg::DATA_WIDTH-1:0] v);
		send_word(mmts_pkg::OP_PUSH, v);
	endtask

	task automatic pop_word();
		send_word(mmts_pkg::OP_POP, mmts_pkg::DATA_WIDTH'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic random_walk(int count, int push_pct);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) idle_on <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < push_pct)
				push_word(pick_value());
			else
				pop_word();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pop_word();
		push_word('0);
		pop_word();
		pop_word();
		push_word({1'b0, {(mmts_pkg::DATA_WIDTH-1){1'b1}}});
		push_word({1'b1, {(mmts_pkg::DATA_WIDTH-1){1'b0}}});
		push_word('1);
		push_word(mmts_pkg::DATA_WIDTH'(1));
		push_word({1'b0, {(mmts_pkg::DATA_WIDTH-1){1'b1}}});
		push_word({1'b1, {(mmts_pkg::DATA_WIDTH-1){1'b0}}});
		push_word('0);
		repeat (4) pop_word();
		push_word(mmts_pkg::DATA_WIDTH'(32'h5555_5555));
		push_word(mmts_pkg::DATA_WIDTH'(32'hAAAA_AAAA));
		repeat (6) pop_word();

		// hold until every result is back, then fill past full and drain past empty
		wait_drained();
		repeat (mmts_pkg::DEPTH + 4) push_word(pick_value());
		repeat (5) begin
			pop_word();
			push_word(pick_value());
		end
		repeat (mmts_pkg::DEPTH + 6) pop_word();

		random_walk(200, 50);
		random_walk(200, 70);
		random_walk(200, 30);
		random_walk(200, 55);
		random_walk(200, 45);

		idle_on <= 1'b0;
		wait_drained();
		for (int i = 0; i < 150; i++) begin
			if ($urandom_range(0, 99) < 50)
				push_word(pick_value());
			else
				pop_word();
		end
		idle_on <= 1'b0;

		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d words; %0d results compared, %0d rejected pops, %0d rejected pushes.",
			words_sent, results_seen, underflows, overflows);
		$display("Stack was filled to capacity and emptied, with random push/pop walks between.");
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
